@@ rtl/qvt_pkg.sv @@
// Shared types, constants and the sine table generator for the quad vertex transform.
package qvt_pkg;

	localparam int SINE_ENTRIES_DEF = 256;
	localparam int SINE_W = 15;
	localparam int ANGLE_FRAC_W = 14;
	localparam int ANGLE_ROUND = 8192;
	localparam int ROUND_BIT = 16;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned TAYLOR_DIV [1:10] =
		'{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] center_z;
		logic [15:0]        turn_angle;
		logic signed [31:0] width;
		logic signed [31:0] height;
		logic signed [31:0] u_low;
		logic signed [31:0] v_low;
		logic signed [31:0] u_high;
		logic signed [31:0] v_high;
		logic [31:0]        rgba;
		logic [7:0]         texture_slot;
	} sprite_t;

	// geometry needed by the transform math
	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic [15:0]        angle;
		logic signed [31:0] w;
		logic signed [31:0] h;
	} geo_t;

	// per-corner fields that ride along unchanged
	typedef struct packed {
		logic signed [31:0] z;
		logic signed [31:0] u;
		logic signed [31:0] v;
		logic [31:0]        rgba;
		logic [7:0]         tex;
		logic [1:0]         corner;
	} pass_t;

	// signed Q1.15 factors with the corner signs folded in
	typedef struct packed {
		logic signed [15:0] cw;
		logic signed [15:0] sh;
		logic signed [15:0] sw;
		logic signed [15:0] ch;
	} factor_t;

	// Q30 Taylor series for sin(x), rounded to Q1.15, clamped below 1.0
	function automatic logic [SINE_W-1:0] sine_q15(input longint unsigned x);
		longint unsigned x2;
		longint unsigned term;
		longint unsigned pos;
		longint unsigned neg;
		longint unsigned r;
		x2 = (x * x) >> 30;
		term = x;
		pos = x;
		neg = 64'd0;
		for (int i = 1; i <= 10; i++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[i];
			if (i % 2 == 1)
				neg = neg + term;
			else
				pos = pos + term;
		end
		r = (pos > neg) ? (pos - neg) : 64'd0;
		r = (r + 64'd16384) >> 15;
		if (r > 64'd32767)
			r = 64'd32767;
		return SINE_W'(r);
	endfunction

endpackage

@@ rtl/qvt_corner_seq.sv @@
// Holds one sprite and issues its four corners, one per transfer.
module qvt_corner_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            sprite_valid,
	output logic            sprite_stall,
	input  qvt_pkg::sprite_t sprite,
	output logic            dn_valid,
	input  logic            dn_ready,
	output qvt_pkg::geo_t   dn_geo,
	output qvt_pkg::pass_t  dn_pass
);
	import qvt_pkg::*;

	sprite_t    sprite_q;
	logic       busy_q;
	logic [1:0] corner_q;
	logic       issue;
	logic       take;

	assign issue = busy_q && dn_ready;
	assign sprite_stall = busy_q && !(dn_ready && corner_q == 2'd3);
	assign take = sprite_valid && !sprite_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			corner_q <= 2'd0;
		end else if (take) begin
			busy_q <= 1'b1;
			corner_q <= 2'd0;
		end else if (issue) begin
			corner_q <= corner_q + 2'd1;
			if (corner_q == 2'd3)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			sprite_q <= sprite;
	end

	assign dn_valid = busy_q;

	always_comb begin
		dn_geo.px = sprite_q.center_x;
		dn_geo.py = sprite_q.center_y;
		dn_geo.angle = sprite_q.turn_angle;
		dn_geo.w = sprite_q.width;
		dn_geo.h = sprite_q.height;
		dn_pass.z = sprite_q.center_z;
		// right corners are 1 and 2, top corners are 2 and 3
		dn_pass.u = (corner_q[0] ^ corner_q[1]) ? sprite_q.u_high : sprite_q.u_low;
		dn_pass.v = corner_q[1] ? sprite_q.v_high : sprite_q.v_low;
		dn_pass.rgba = sprite_q.rgba;
		dn_pass.tex = sprite_q.texture_slot;
		dn_pass.corner = corner_q;
	end

endmodule

@@ rtl/qvt_trig.sv @@
// Sine table lookup and quadrant/corner sign folding (stages 1 and 2).
module qvt_trig #(
	parameter int SINE_ENTRIES = qvt_pkg::SINE_ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	output logic             up_ready,
	input  qvt_pkg::geo_t    up_geo,
	input  qvt_pkg::pass_t   up_pass,
	output logic             dn_valid,
	input  logic             dn_ready,
	output qvt_pkg::geo_t    dn_geo,
	output qvt_pkg::pass_t   dn_pass,
	output qvt_pkg::factor_t dn_fac
);
	import qvt_pkg::*;

	localparam int IDX_W = $clog2(SINE_ENTRIES + 1);
	localparam int PROD_W = ANGLE_FRAC_W + IDX_W + 1;

	logic [SINE_W-1:0] sine_rom [0:SINE_ENTRIES];

	for (genvar k = 0; k <= SINE_ENTRIES; k++) begin : g_rom
		localparam longint unsigned ANG_X = (HALF_PI_Q30 * k) / SINE_ENTRIES;
		assign sine_rom[k] = sine_q15(ANG_X);
	end

	logic [PROD_W-1:0] idx_prod;
	logic [IDX_W-1:0]  idx_a;
	logic [IDX_W-1:0]  idx_b;

	logic              v_s1;
	geo_t              geo_s1;
	pass_t             pass_s1;
	logic [SINE_W-1:0] a_s1;
	logic [SINE_W-1:0] b_s1;

	logic              v_s2;
	geo_t              geo_s2;
	pass_t             pass_s2;
	factor_t           fac_s2;

	logic              rdy_s1;
	logic              rdy_s2;
	logic signed [15:0] sin_v;
	logic signed [15:0] cos_v;
	logic signed [15:0] a_sv;
	logic signed [15:0] b_sv;
	logic              sgx;
	logic              sgy;
	factor_t           fac_d;

	assign rdy_s2 = !v_s2 || dn_ready;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	// nearest table entry for the angle within the quadrant
	always_comb begin
		idx_prod = PROD_W'(up_geo.angle[ANGLE_FRAC_W-1:0]) * PROD_W'(SINE_ENTRIES)
			+ PROD_W'(ANGLE_ROUND);
		idx_a = IDX_W'(idx_prod >> ANGLE_FRAC_W);
		idx_b = IDX_W'(SINE_ENTRIES) - idx_a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (rdy_s1)
			v_s1 <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			geo_s1 <= up_geo;
			pass_s1 <= up_pass;
			a_s1 <= sine_rom[idx_a];
			b_s1 <= sine_rom[idx_b];
		end
	end

	always_comb begin
		a_sv = 16'(a_s1);
		b_sv = 16'(b_s1);
		case (geo_s1.angle[15:14])
			2'd0: begin
				sin_v = a_sv;
				cos_v = b_sv;
			end
			2'd1: begin
				sin_v = b_sv;
				cos_v = -a_sv;
			end
			2'd2: begin
				sin_v = -a_sv;
				cos_v = -b_sv;
			end
			default: begin
				sin_v = -b_sv;
				cos_v = a_sv;
			end
		endcase
		sgx = pass_s1.corner[0] ^ pass_s1.corner[1];
		sgy = pass_s1.corner[1];
		fac_d.cw = sgx ? cos_v : -cos_v;
		fac_d.sh = sgy ? sin_v : -sin_v;
		fac_d.sw = sgx ? sin_v : -sin_v;
		fac_d.ch = sgy ? cos_v : -cos_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (rdy_s2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			geo_s2 <= geo_s1;
			pass_s2 <= pass_s1;
			fac_s2 <= fac_d;
		end
	end

	assign dn_valid = v_s2;
	assign dn_geo = geo_s2;
	assign dn_pass = pass_s2;
	assign dn_fac = fac_s2;

endmodule

@@ rtl/qvt_vertex_math.sv @@
// Products, rounding and saturation of the corner offsets (stages 3 to 5).
module qvt_vertex_math (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	output logic             up_ready,
	input  qvt_pkg::geo_t    up_geo,
	input  qvt_pkg::pass_t   up_pass,
	input  qvt_pkg::factor_t up_fac,
	output logic             vertex_valid,
	input  logic             vertex_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output qvt_pkg::pass_t   out_pass,
	output logic             out_clip
);
	import qvt_pkg::*;

	logic               v_s3;
	logic signed [47:0] pcw_s3;
	logic signed [47:0] psh_s3;
	logic signed [47:0] psw_s3;
	logic signed [47:0] pch_s3;
	logic signed [31:0] px_s3;
	logic signed [31:0] py_s3;
	pass_t              pass_s3;

	logic               v_s4;
	logic signed [32:0] rx_s4;
	logic signed [32:0] ry_s4;
	logic signed [31:0] px_s4;
	logic signed [31:0] py_s4;
	pass_t              pass_s4;

	logic               v_s5;
	logic signed [31:0] x_s5;
	logic signed [31:0] y_s5;
	logic               clip_s5;
	pass_t              pass_s5;

	logic rdy_s3;
	logic rdy_s4;
	logic rdy_s5;

	logic signed [48:0] dx_r;
	logic signed [48:0] dy_r;
	logic signed [33:0] sx;
	logic signed [33:0] sy;
	logic signed [31:0] x_sat;
	logic signed [31:0] y_sat;
	logic               clip_x;
	logic               clip_y;

	localparam logic signed [33:0] MAX32 = 34'sd2147483647;
	localparam logic signed [33:0] MIN32 = -34'sd2147483648;

	assign rdy_s5 = !v_s5 || !vertex_stall;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign up_ready = rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s3)
				v_s3 <= up_valid;
			if (rdy_s4)
				v_s4 <= v_s3;
			if (rdy_s5)
				v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && up_valid) begin
			pcw_s3 <= 48'(up_fac.cw) * 48'(up_geo.w);
			psh_s3 <= 48'(up_fac.sh) * 48'(up_geo.h);
			psw_s3 <= 48'(up_fac.sw) * 48'(up_geo.w);
			pch_s3 <= 48'(up_fac.ch) * 48'(up_geo.h);
			px_s3 <= up_geo.px;
			py_s3 <= up_geo.py;
			pass_s3 <= up_pass;
		end
	end

	// offset sum, then drop 16 bits rounding half up
	always_comb begin
		dx_r = 49'(pcw_s3) - 49'(psh_s3) + 49'sd32768;
		dy_r = 49'(psw_s3) + 49'(pch_s3) + 49'sd32768;
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			rx_s4 <= dx_r[48:ROUND_BIT];
			ry_s4 <= dy_r[48:ROUND_BIT];
			px_s4 <= px_s3;
			py_s4 <= py_s3;
			pass_s4 <= pass_s3;
		end
	end

	always_comb begin
		sx = 34'(rx_s4) + 34'(px_s4);
		sy = 34'(ry_s4) + 34'(py_s4);
		clip_x = (sx > MAX32) || (sx < MIN32);
		clip_y = (sy > MAX32) || (sy < MIN32);
		if (sx > MAX32)
			x_sat = 32'sh7fffffff;
		else if (sx < MIN32)
			x_sat = 32'sh80000000;
		else
			x_sat = sx[31:0];
		if (sy > MAX32)
			y_sat = 32'sh7fffffff;
		else if (sy < MIN32)
			y_sat = 32'sh80000000;
		else
			y_sat = sy[31:0];
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			x_s5 <= x_sat;
			y_s5 <= y_sat;
			clip_s5 <= clip_x || clip_y;
			pass_s5 <= pass_s4;
		end
	end

	assign vertex_valid = v_s5;
	assign out_x = x_s5;
	assign out_y = y_s5;
	assign out_pass = pass_s5;
	assign out_clip = clip_s5;

endmodule

@@ rtl/quad_vertex_transform.sv @@
// Top level: sprite in, four transformed quad vertices out.
// Order: the first vertex of a sprite passes the sequencer register and each stage in turn,
// and the other three follow in corner order; the next sprite waits for the fourth.
// Throughput: one vertex per cycle while vertex_stall is low, set by the corner sequencer
// feeding the single vertex channel; the stages take a vertex every cycle unless stalled.
// Reset clears the sequencer and all stage valid bits; the sine table is constant logic.
module quad_vertex_transform #(
	parameter int SINE_ENTRIES = qvt_pkg::SINE_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sprite_valid,
	output logic               sprite_stall,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic signed [31:0] center_z,
	input  logic [15:0]        turn_angle,
	input  logic signed [31:0] width,
	input  logic signed [31:0] height,
	input  logic signed [31:0] u_low,
	input  logic signed [31:0] v_low,
	input  logic signed [31:0] u_high,
	input  logic signed [31:0] v_high,
	input  logic [31:0]        rgba,
	input  logic [7:0]         texture_slot,
	output logic               vertex_valid,
	input  logic               vertex_stall,
	output logic signed [31:0] vtx_x,
	output logic signed [31:0] vtx_y,
	output logic signed [31:0] vtx_z,
	output logic signed [31:0] tex_u,
	output logic signed [31:0] tex_v,
	output logic [31:0]        vtx_rgba,
	output logic [7:0]         vtx_texture,
	output logic [1:0]         corner,
	output logic               last_vertex,
	output logic               clipped
);
	import qvt_pkg::*;

	sprite_t sprite;
	logic    seq_valid;
	logic    seq_ready;
	geo_t    seq_geo;
	pass_t   seq_pass;
	logic    trig_valid;
	logic    trig_ready;
	geo_t    trig_geo;
	pass_t   trig_pass;
	factor_t trig_fac;
	pass_t   out_pass;

	always_comb begin
		sprite.center_x = center_x;
		sprite.center_y = center_y;
		sprite.center_z = center_z;
		sprite.turn_angle = turn_angle;
		sprite.width = width;
		sprite.height = height;
		sprite.u_low = u_low;
		sprite.v_low = v_low;
		sprite.u_high = u_high;
		sprite.v_high = v_high;
		sprite.rgba = rgba;
		sprite.texture_slot = texture_slot;
	end

	qvt_corner_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.sprite_valid (sprite_valid),
		.sprite_stall (sprite_stall),
		.sprite       (sprite),
		.dn_valid     (seq_valid),
		.dn_ready     (seq_ready),
		.dn_geo       (seq_geo),
		.dn_pass      (seq_pass)
	);

	qvt_trig #(
		.SINE_ENTRIES (SINE_ENTRIES)
	) u_trig (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (seq_valid),
		.up_ready (seq_ready),
		.up_geo   (seq_geo),
		.up_pass  (seq_pass),
		.dn_valid (trig_valid),
		.dn_ready (trig_ready),
		.dn_geo   (trig_geo),
		.dn_pass  (trig_pass),
		.dn_fac   (trig_fac)
	);

	qvt_vertex_math u_math (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_valid     (trig_valid),
		.up_ready     (trig_ready),
		.up_geo       (trig_geo),
		.up_pass      (trig_pass),
		.up_fac       (trig_fac),
		.vertex_valid (vertex_valid),
		.vertex_stall (vertex_stall),
		.out_x        (vtx_x),
		.out_y        (vtx_y),
		.out_pass     (out_pass),
		.out_clip     (clipped)
	);

	assign vtx_z = out_pass.z;
	assign tex_u = out_pass.u;
	assign tex_v = out_pass.v;
	assign vtx_rgba = out_pass.rgba;
	assign vtx_texture = out_pass.tex;
	assign corner = out_pass.corner;
	assign last_vertex = (out_pass.corner == 2'd3);

endmodule
